// ===== rtl/core/dts_pkg.sv =====
// ----------------------------------------------------------------------------
// dts_pkg
// Types and constants shared by the deadline timer scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package dts_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int MAX_RESULTS = 63;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SCHED  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [1:0] KIND_FIRED  = 2'd0;
  localparam logic [1:0] KIND_SCHED  = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] now_ms;
    logic [31:0] delay_ms;
    logic        repeat_req;
    logic [31:0] tag;
    logic [5:0]  entry_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot_id;
    logic [31:0] fired_tag;
    logic [63:0] remaining_ms;
    logic        last;
  } rsp_t;

  // one memory word per slot
  typedef struct packed {
    logic [63:0] deadline;
    logic [31:0] period;
    logic        repeating;
    logic [31:0] entry_tag;
    logic        cancelled;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/dts_mem.sv =====
// ----------------------------------------------------------------------------
// dts_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dts_mem #(
  parameter int ENTRIES = dts_pkg::ENTRIES_DEF,
  localparam int AW = $clog2(ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire dts_pkg::entry_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output dts_pkg::entry_t      rdata
);

  dts_pkg::entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/deadline_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_scheduler
// Timer queue with per-slot storage in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage: drive cmd and raise start while busy is low; the item is taken at
// that edge. Results leave on rsp with rsp_valid high for one cycle each;
// rsp.last marks the final result of an item. The receiver cannot stall,
// so no backpressure exists.
// Schedule: the free slot search uses a flip-flop occupancy vector and the
// memory is written at the accepting edge; busy never rises, the result is
// out in the next cycle and a new item can be taken at the next edge.
// Cancel reads the slot in S_CRD, then answers from S_CANS; the registered
// result leaves in the same cycle that busy falls.
// Tick: each round sweeps all ENTRIES slots through the memory read port
// (one slot per cycle) to find the earliest expired entry, then reads and
// updates that slot; rounds repeat until a sweep finds no such entry.
// Each fired result is held and leaves when the next one fires, or as the
// last result at the end of the tick.
// Reset clears occupancy and the count at once; slot contents stay
// undefined until written. Mode 3 items finish without a result.
// ----------------------------------------------------------------------------
`default_nettype none
module deadline_timer_scheduler #(
  parameter int ENTRIES = dts_pkg::ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire dts_pkg::cmd_t cmd,
  output logic               rsp_valid,
  output dts_pkg::rsp_t      rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRD   = 3'd1;
  localparam logic [2:0] S_CANS  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]          state;
  dts_pkg::cmd_t       c;
  logic [ENTRIES-1:0]  occupied;
  logic [ENTRIES-1:0]  done;
  logic [CW-1:0]       live_count;
  logic [AW:0]         scan_idx;
  logic [AW-1:0]       chk_idx;
  logic                chk_ok;
  logic                best_ok;
  logic [AW-1:0]       best_idx;
  logic [63:0]         best_dl;
  logic [5:0]          nres;
  logic                any_out;
  dts_pkg::rsp_t       held;
  dts_pkg::rsp_t       fire;
  dts_pkg::rsp_t       rsp_next;
  logic                rsp_valid_next;

  logic                we;
  logic [AW-1:0]       waddr;
  dts_pkg::entry_t     wdata;
  logic [AW-1:0]       raddr;
  dts_pkg::entry_t     rdata;

  dts_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // lowest free slot
  logic          free_ok;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!occupied[i]) begin
        free_ok  = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic sched_ok;
  assign sched_ok = free_ok && (32'(live_count) + 32'd1 < 32'(ENTRIES));

  logic id_in;
  assign id_in = ({26'd0, c.entry_id} < 32'(ENTRIES)) && occupied[AW'(c.entry_id)];

  logic cand;
  assign cand = chk_ok && occupied[chk_idx] && !done[chk_idx] && (rdata.deadline <= c.now_ms);

  logic fire_now;
  assign fire_now = !rdata.cancelled && nres < 6'(dts_pkg::MAX_RESULTS);

  assign busy = (state != S_IDLE);

  always_comb begin
    raddr = scan_idx[AW-1:0];
    if (state == S_IDLE) raddr = AW'(cmd.entry_id);
    else if (state == S_CRD) raddr = AW'(c.entry_id);
    else if (state == S_PICK) raddr = best_idx;
  end

  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wdata = rdata;
    if (state == S_IDLE && start && cmd.mode == dts_pkg::MODE_SCHED && sched_ok) begin
      we              = 1'b1;
      waddr           = free_idx;
      wdata.deadline  = cmd.now_ms + {32'd0, cmd.delay_ms};
      wdata.period    = cmd.delay_ms;
      wdata.repeating = cmd.repeat_req;
      wdata.entry_tag = cmd.tag;
      wdata.cancelled = 1'b0;
    end else if (state == S_CANS) begin
      we              = id_in;
      waddr           = AW'(c.entry_id);
      wdata.cancelled = 1'b1;
    end else if (state == S_UPD) begin
      we             = fire_now && rdata.repeating;
      wdata.deadline = c.now_ms + {32'd0, rdata.period};
    end
  end

  always_comb begin
    fire           = '0;
    fire.kind      = dts_pkg::KIND_FIRED;
    fire.slot_id   = 6'(best_idx);
    fire.fired_tag = rdata.entry_tag;
  end

  always_comb begin
    rsp_valid_next = 1'b0;
    rsp_next       = rsp;
    if (state == S_IDLE && start && cmd.mode == dts_pkg::MODE_SCHED) begin
      rsp_valid_next = 1'b1;
      rsp_next       = '0;
      rsp_next.last  = 1'b1;
      if (sched_ok) begin
        rsp_next.kind    = dts_pkg::KIND_SCHED;
        rsp_next.slot_id = 6'(free_idx);
      end else begin
        rsp_next.kind = dts_pkg::KIND_FULL;
      end
    end else if (state == S_CANS) begin
      rsp_valid_next        = 1'b1;
      rsp_next              = '0;
      rsp_next.kind         = dts_pkg::KIND_CANCEL;
      rsp_next.slot_id      = c.entry_id;
      rsp_next.last         = 1'b1;
      rsp_next.remaining_ms = (id_in && rdata.deadline >= c.now_ms) ?
                              rdata.deadline - c.now_ms : 64'd0;
    end else if (state == S_UPD && any_out && fire_now) begin
      rsp_valid_next = 1'b1;
      rsp_next       = held;
    end else if (state == S_FIN && any_out) begin
      // the held result goes out last
      rsp_valid_next = 1'b1;
      rsp_next       = held;
      rsp_next.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      rsp       <= '0;
    end else begin
      rsp_valid <= rsp_valid_next;
      rsp       <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      occupied   <= '0;
      live_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            c <= cmd;
            unique case (cmd.mode)
              dts_pkg::MODE_SCHED: begin
                if (sched_ok) begin
                  occupied[free_idx] <= 1'b1;
                  live_count <= live_count + 1'b1;
                end
              end
              dts_pkg::MODE_CANCEL: state <= S_CRD;
              dts_pkg::MODE_TICK: begin
                done     <= '0;
                nres     <= '0;
                any_out  <= 1'b0;
                scan_idx <= '0;
                best_ok  <= 1'b0;
                chk_ok   <= 1'b0;
                state    <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_CRD: state <= S_CANS;
        S_CANS: state <= S_IDLE;
        S_SCAN: begin
          chk_ok  <= (scan_idx < (AW+1)'(ENTRIES));
          chk_idx <= scan_idx[AW-1:0];
          if (scan_idx <= (AW+1)'(ENTRIES)) scan_idx <= scan_idx + 1'b1;
          if (cand && (!best_ok || rdata.deadline < best_dl)) begin
            best_ok  <= 1'b1;
            best_idx <= chk_idx;
            best_dl  <= rdata.deadline;
          end
          if (scan_idx == (AW+1)'(ENTRIES + 1)) state <= S_PICK;
        end
        S_PICK: begin
          if (best_ok) begin
            state <= S_UPD;
          end else begin
            state <= S_FIN;
          end
        end
        S_UPD: begin
          if (rdata.cancelled) begin
            occupied[best_idx] <= 1'b0;
            if (live_count != '0) live_count <= live_count - 1'b1;
          end else if (nres >= 6'(dts_pkg::MAX_RESULTS)) begin
            done[best_idx] <= 1'b1;
          end else begin
            held    <= fire;
            any_out <= 1'b1;
            nres    <= nres + 1'b1;
            if (rdata.repeating) begin
              done[best_idx] <= 1'b1;
            end else begin
              occupied[best_idx] <= 1'b0;
              if (live_count != '0) live_count <= live_count - 1'b1;
            end
          end
          scan_idx <= '0;
          best_ok  <= 1'b0;
          chk_ok   <= 1'b0;
          state    <= S_SCAN;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
